// File: sv/sm3_pkg.sv
// ----------------------------------------------------------------------------
// sm3_pkg
// types, constants and helper functions shared by the sm3 hash unit
// ----------------------------------------------------------------------------
package sm3_pkg;

  // one input item: big-endian message word
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
  } sm3_in_t;

  // one result item: the 256-bit digest, two chaining words per field
  typedef struct packed {
    logic [63:0] digest_0;
    logic [63:0] digest_1;
    logic [63:0] digest_2;
    logic [63:0] digest_3;
  } sm3_out_t;

  // eight 32-bit words, index 0 is a / V0
  typedef logic [7:0][31:0] sm3_words_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD
  } sm3_state_e;

  // message schedule control
  typedef struct packed {
    logic        push;
    logic        expand;
    logic [31:0] word;
  } sm3_sched_ctrl_t;

  // compression round control
  typedef struct packed {
    logic load;
    logic step;
    logic low_phase;
    logic t_switch;
  } sm3_rnd_ctrl_t;

  localparam logic [31:0] SM3_T_LOW    = 32'h79CC_4519;
  localparam logic [31:0] SM3_T_HIGH   = 32'h7A87_9D8A;
  // t constant of round 16 is the high constant rotated left by 16
  localparam logic [31:0] SM3_T_HIGH16 = {SM3_T_HIGH[15:0], SM3_T_HIGH[31:16]};
  localparam logic [31:0] SM3_MARKER   = 32'h8000_0000;

  localparam int unsigned SM3_ROUNDS    = 64;
  localparam int unsigned SM3_BLK_WORDS = 16;
  localparam logic [3:0]  SM3_LEN_HI_IDX = 4'd14;
  localparam logic [3:0]  SM3_LEN_LO_IDX = 4'd15;

  localparam sm3_words_t SM3_IV = {
    32'hB0FB_0E4E, 32'hE38D_EE4D, 32'h1631_38AA, 32'hA96F_30BC,
    32'hDA8A_0600, 32'h1724_42D7, 32'h4914_B2B9, 32'h7380_166F
  };

  // rotate left by a constant amount in 1..31
  function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned k);
    rotl32 = (x << k) | (x >> (32 - k));
  endfunction

  function automatic logic [31:0] perm0(logic [31:0] x);
    perm0 = x ^ rotl32(x, 9) ^ rotl32(x, 17);
  endfunction

  function automatic logic [31:0] perm1(logic [31:0] x);
    perm1 = x ^ rotl32(x, 15) ^ rotl32(x, 23);
  endfunction

  // final partial word: keep valid bytes, marker byte right after them
  function automatic logic [31:0] pad_word(logic [31:0] data, logic [1:0] nbytes);
    logic [31:0] res;
    unique case (nbytes)
      2'd0: res = SM3_MARKER;
      2'd1: res = {data[31:24], 24'h80_0000};
      2'd2: res = {data[31:16], 16'h8000};
      2'd3: res = {data[31:8], 8'h80};
      default: res = SM3_MARKER;
    endcase
    pad_word = res;
  endfunction

endpackage

// File: sv/sm3_msg_sched.sv
// ----------------------------------------------------------------------------
// sm3_msg_sched
// 16-word message window: loads block words, then expands one word per round
// ----------------------------------------------------------------------------
module sm3_msg_sched (
  input  logic                     clk_i,
  input  sm3_pkg::sm3_sched_ctrl_t ctrl_i,
  output logic [31:0]              w_j_o,
  output logic [31:0]              w_j4_o
);

  logic [15:0][31:0] win_q;
  logic [15:0][31:0] win_d;
  logic [31:0]       w_new;

  // w[j+16] from taps j, j+3, j+7, j+10, j+13
  assign w_new = sm3_pkg::perm1(win_q[0] ^ win_q[7] ^ sm3_pkg::rotl32(win_q[13], 15))
               ^ sm3_pkg::rotl32(win_q[3], 7) ^ win_q[10];

  always_comb begin
    win_d = win_q;
    if (ctrl_i.push || ctrl_i.expand) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i + 1];
      end
      win_d[15] = ctrl_i.push ? ctrl_i.word : w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign w_j_o  = win_q[0];
  assign w_j4_o = win_q[4];

endmodule

// File: sv/sm3_round.sv
// ----------------------------------------------------------------------------
// sm3_round
// compression state a..h, one round per step
// ----------------------------------------------------------------------------
module sm3_round (
  input  logic                   clk_i,
  input  sm3_pkg::sm3_rnd_ctrl_t ctrl_i,
  input  sm3_pkg::sm3_words_t    chain_i,
  input  logic [31:0]            w_j_i,
  input  logic [31:0]            w_j4_i,
  output sm3_pkg::sm3_words_t    state_o
);

  sm3_pkg::sm3_words_t st_q, st_d;
  logic [31:0] tj_q, tj_d;
  logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2;

  always_comb begin
    a12 = sm3_pkg::rotl32(st_q[0], 12);
    ss1 = sm3_pkg::rotl32(a12 + st_q[4] + tj_q, 7);
    ss2 = ss1 ^ a12;
    if (ctrl_i.low_phase) begin
      ffv = st_q[0] ^ st_q[1] ^ st_q[2];
      ggv = st_q[4] ^ st_q[5] ^ st_q[6];
    end else begin
      ffv = (st_q[0] & st_q[1]) | (st_q[0] & st_q[2]) | (st_q[1] & st_q[2]);
      ggv = (st_q[4] & st_q[5]) | (~st_q[4] & st_q[6]);
    end
    tt1 = ffv + st_q[3] + ss2 + (w_j_i ^ w_j4_i);
    tt2 = ggv + st_q[7] + ss1 + w_j_i;
  end

  always_comb begin
    st_d = st_q;
    tj_d = tj_q;
    if (ctrl_i.load) begin
      st_d = chain_i;
      tj_d = sm3_pkg::SM3_T_LOW;
    end else if (ctrl_i.step) begin
      st_d[0] = tt1;
      st_d[1] = st_q[0];
      st_d[2] = sm3_pkg::rotl32(st_q[1], 9);
      st_d[3] = st_q[2];
      st_d[4] = sm3_pkg::perm0(tt2);
      st_d[5] = st_q[4];
      st_d[6] = sm3_pkg::rotl32(st_q[5], 19);
      st_d[7] = st_q[6];
      tj_d    = ctrl_i.t_switch ? sm3_pkg::SM3_T_HIGH16 : sm3_pkg::rotl32(tj_q, 1);
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    tj_q <= tj_d;
  end

  assign state_o = st_q;

endmodule

// File: sv/sm3_hash_unit.sv
// ----------------------------------------------------------------------------
// sm3_hash_unit
// SM3 256-bit hash over a stream of big-endian 32-bit message words
// ----------------------------------------------------------------------------
//
// channel | dir | handshake                  | payload
// --------+-----+----------------------------+-----------------------------------
// in      | in  | in_valid_i / in_stall_o    | in_data_i  (data_word, byte_count, last)
// out     | out | out_valid_o / out_stall_i  | out_data_o (digest_0 .. digest_3)
//
// words are taken one per cycle while idle; the 16th word of a block starts
// 64 compression rounds, one per cycle on a single round unit, then a fold of
// the result into the chaining value
// a last word adds one padding word per cycle up to the block end and then
// the rounds and fold; when the length spills over, a second block of 16
// padding words, rounds and fold follows before the digest is registered on
// out
// in_stall_o is high whenever the sequencer is not idle
// a waiting digest does not block new words; only the next digest waits
// on out_stall_i. reset restores the initial value and clears all control
// ----------------------------------------------------------------------------
module sm3_hash_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sm3_pkg::sm3_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sm3_pkg::sm3_out_t out_data_o
);

  sm3_pkg::sm3_state_e state_q, state_d;

  // block position and message length
  logic [3:0]  idx_q, idx_d;
  logic [63:0] bits_q, bits_d;
  // padding progress
  logic        pad_q, pad_d;          // message end seen, padding under way
  logic        marker_q, marker_d;    // marker word still to be pushed
  logic        len_ok_q, len_ok_d;    // length fits at the end of this block
  logic        last_blk_q, last_blk_d; // block in flight carries the length
  logic [5:0]  round_q, round_d;

  sm3_pkg::sm3_words_t chain_q, chain_d;
  sm3_pkg::sm3_words_t rnd_state;
  sm3_pkg::sm3_words_t folded;

  logic              out_valid_q, out_valid_d;
  sm3_pkg::sm3_out_t out_data_q, out_data_d;

  sm3_pkg::sm3_sched_ctrl_t sched_ctrl;
  sm3_pkg::sm3_rnd_ctrl_t   rnd_ctrl;
  logic [31:0]              w_j, w_j4;

  // input decode
  logic       accept;
  logic       full_word;
  logic [2:0] eff_bytes;
  logic       blk_done;
  logic       fold_go;

  assign accept    = in_valid_i && (state_q == sm3_pkg::S_IDLE);
  // short counts only count with last; anything above four is four
  assign full_word = !in_data_i.last || in_data_i.byte_count[2];
  assign eff_bytes = full_word ? 3'd4 : in_data_i.byte_count;
  assign blk_done  = sched_ctrl.push && (idx_q == sm3_pkg::SM3_LEN_LO_IDX);
  // the digest slot must be free before the last fold
  assign fold_go   = !last_blk_q || !out_valid_q || !out_stall_i;
  assign folded    = chain_q ^ rnd_state;

  // ---------------------------------------------------------------------------
  // datapath control and register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    sched_ctrl  = '0;
    rnd_ctrl    = '0;
    idx_d       = idx_q;
    bits_d      = bits_q;
    pad_d       = pad_q;
    marker_d    = marker_q;
    len_ok_d    = len_ok_q;
    last_blk_d  = last_blk_q;
    round_d     = round_q;
    chain_d     = chain_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      sm3_pkg::S_IDLE: begin
        if (accept) begin
          sched_ctrl.push = 1'b1;
          bits_d = bits_q + {58'd0, eff_bytes, 3'b000};
          if (in_data_i.last) begin
            pad_d = 1'b1;
            if (full_word) begin
              // full last word: marker goes in its own word
              sched_ctrl.word = in_data_i.data_word;
              marker_d = 1'b1;
            end else begin
              sched_ctrl.word = sm3_pkg::pad_word(in_data_i.data_word, eff_bytes[1:0]);
              len_ok_d = (idx_q != sm3_pkg::SM3_LEN_HI_IDX);
            end
          end else begin
            sched_ctrl.word = in_data_i.data_word;
          end
        end
      end
      sm3_pkg::S_PAD: begin
        sched_ctrl.push = 1'b1;
        if (marker_q) begin
          sched_ctrl.word = sm3_pkg::SM3_MARKER;
          marker_d = 1'b0;
          len_ok_d = (idx_q != sm3_pkg::SM3_LEN_HI_IDX);
        end else if (len_ok_q && idx_q == sm3_pkg::SM3_LEN_HI_IDX) begin
          sched_ctrl.word = bits_q[63:32];
        end else if (len_ok_q && idx_q == sm3_pkg::SM3_LEN_LO_IDX) begin
          sched_ctrl.word = bits_q[31:0];
          last_blk_d = 1'b1;
        end else begin
          // zero fill; reaching the block end with it means the length goes in the next one
          sched_ctrl.word = '0;
          if (idx_q == sm3_pkg::SM3_LEN_LO_IDX) begin
            len_ok_d = 1'b1;
          end
        end
      end
      sm3_pkg::S_ROUND: begin
        sched_ctrl.expand  = 1'b1;
        rnd_ctrl.step      = 1'b1;
        rnd_ctrl.low_phase = (round_q[5:4] == 2'b00);
        rnd_ctrl.t_switch  = (round_q == 6'd15);
        round_d            = round_q + 6'd1;
      end
      sm3_pkg::S_FOLD: begin
        if (fold_go) begin
          if (last_blk_q) begin
            out_valid_d         = 1'b1;
            out_data_d.digest_0 = {folded[0], folded[1]};
            out_data_d.digest_1 = {folded[2], folded[3]};
            out_data_d.digest_2 = {folded[4], folded[5]};
            out_data_d.digest_3 = {folded[6], folded[7]};
            chain_d    = sm3_pkg::SM3_IV;
            bits_d     = '0;
            pad_d      = 1'b0;
            len_ok_d   = 1'b0;
            last_blk_d = 1'b0;
          end else begin
            chain_d = folded;
          end
        end
      end
      default: ;
    endcase

    if (sched_ctrl.push) begin
      idx_d = idx_q + 4'd1;
    end
    // block complete: start the rounds from the current chaining value
    if (blk_done) begin
      rnd_ctrl.load = 1'b1;
      round_d       = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sm3_pkg::S_IDLE: begin
        if (accept) begin
          priority if (blk_done) begin
            state_d = sm3_pkg::S_ROUND;
          end else if (in_data_i.last) begin
            state_d = sm3_pkg::S_PAD;
          end
        end
      end
      sm3_pkg::S_PAD: begin
        if (blk_done) begin
          state_d = sm3_pkg::S_ROUND;
        end
      end
      sm3_pkg::S_ROUND: begin
        if (round_q == 6'(sm3_pkg::SM3_ROUNDS - 1)) begin
          state_d = sm3_pkg::S_FOLD;
        end
      end
      sm3_pkg::S_FOLD: begin
        if (fold_go) begin
          state_d = (pad_q && !last_blk_q) ? sm3_pkg::S_PAD : sm3_pkg::S_IDLE;
        end
      end
      default: state_d = sm3_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sm3_pkg::S_IDLE;
      idx_q       <= '0;
      bits_q      <= '0;
      pad_q       <= 1'b0;
      marker_q    <= 1'b0;
      len_ok_q    <= 1'b0;
      last_blk_q  <= 1'b0;
      round_q     <= '0;
      chain_q     <= sm3_pkg::SM3_IV;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      bits_q      <= bits_d;
      pad_q       <= pad_d;
      marker_q    <= marker_d;
      len_ok_q    <= len_ok_d;
      last_blk_q  <= last_blk_d;
      round_q     <= round_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // digest payload, qualified by out_valid_q
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  sm3_msg_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_j_o  (w_j),
    .w_j4_o (w_j4)
  );

  sm3_round u_round (
    .clk_i   (clk_i),
    .ctrl_i  (rnd_ctrl),
    .chain_i (chain_q),
    .w_j_i   (w_j),
    .w_j4_i  (w_j4),
    .state_o (rnd_state)
  );

  assign in_stall_o  = (state_q != sm3_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
